>>> design/elex_pkg.sv
package elex_pkg;

    localparam int POS_BITS_DEF    = 16;
    localparam int MAX_FRAC_DEF    = 9;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int SLOTS           = 3;

    localparam logic [2:0]  HDR_LEN   = 3'd6;
    localparam logic [15:0] LIT_RESET = 16'd1;

    typedef enum logic [3:0] {
        M_HDR_WS,
        M_HDR,
        M_IDLE,
        M_IDENT,
        M_INT,
        M_DEC,
        M_STR,
        M_COMMENT,
        M_ERROR
    } mode_t;

    typedef enum logic [1:0] {
        P_NONE,
        P_SLASH,
        P_EQ
    } pend_t;

    typedef enum logic [3:0] {
        K_ADD    = 4'd0,
        K_SUB    = 4'd1,
        K_MUL    = 4'd2,
        K_DIV    = 4'd3,
        K_LPAREN = 4'd4,
        K_RPAREN = 4'd5,
        K_ASSIGN = 4'd6,
        K_IDENT  = 4'd7,
        K_INT    = 4'd8,
        K_DEC    = 4'd9,
        K_STR    = 4'd10,
        K_EOF    = 4'd11,
        K_ERR    = 4'd12
    } kind_t;

    typedef enum logic [2:0] {
        E_NONE    = 3'd0,
        E_HEADER  = 3'd1,
        E_COMMENT = 3'd2,
        E_STRING  = 3'd3,
        E_CHAR    = 3'd4
    } err_t;

    typedef struct packed {
        kind_t       kind;
        err_t        err;
        logic [15:0] start_pos;
        logic [15:0] end_pos;
    } tok_t;

    // All tokens caused by one byte; at most one of them carries number or
    // literal fields, so those are shared.
    typedef struct packed {
        logic [1:0]           count;
        tok_t [SLOTS-1:0]     slot;
        logic [63:0]          int_value;
        logic [29:0]          frac_value;
        logic [3:0]           frac_digits;
        logic [15:0]          lit_num;
    } bundle_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic [7:0] hdr_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = "m";
            3'd1:    c = "a";
            3'd2:    c = "i";
            3'd3:    c = "n";
            3'd4:    c = ":";
            3'd5:    c = 8'h0A;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

>>> design/elex_front.sv
module elex_front
    import elex_pkg::*;
#(
    parameter int POS_BITS        = POS_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_fire,
    input  logic [7:0] ch,
    input  logic       end_of_text,
    output bundle_t    bundle
);

    localparam int CNT_W = $clog2(MAX_FRAC_DIGITS + 1);

    mode_t               mode_reg, mode_next;
    logic [2:0]          hidx_reg, hidx_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] ts_reg, ts_next;
    logic [63:0]         acc_reg, acc_next;
    logic [29:0]         frac_reg, frac_next;
    logic [CNT_W-1:0]    fcnt_reg, fcnt_next;
    logic                quote_reg, quote_next;
    pend_t               pend_reg, pend_next;
    logic                star_reg, star_next;
    logic [15:0]         lit_reg, lit_next;

    logic [POS_BITS-1:0] p, p1;
    logic [3:0]          digit;
    logic                do_idle;
    bundle_t             b;

    function automatic bundle_t push(input bundle_t bin, input kind_t k, input err_t e,
                                     input logic [15:0] s, input logic [15:0] en);
        bundle_t r;
        tok_t    t;
        r = bin;
        t.kind      = k;
        t.err       = e;
        t.start_pos = s;
        t.end_pos   = en;
        unique case (bin.count)
            2'd0:    r.slot[0] = t;
            2'd1:    r.slot[1] = t;
            2'd2:    r.slot[2] = t;
            default: r.slot[2] = bin.slot[2];
        endcase
        if (bin.count != 2'd3)
        begin
            r.count = bin.count + 2'd1;
        end
        return r;
    endfunction

    always_comb
    begin
        mode_next  = mode_reg;
        hidx_next  = hidx_reg;
        pos_next   = pos_reg;
        ts_next    = ts_reg;
        acc_next   = acc_reg;
        frac_next  = frac_reg;
        fcnt_next  = fcnt_reg;
        quote_next = quote_reg;
        pend_next  = pend_reg;
        star_next  = star_reg;
        lit_next   = lit_reg;
        b          = '0;
        do_idle    = 1'b0;
        p          = pos_reg;
        p1         = pos_reg + 1'b1;
        digit      = ch[3:0];

        if (in_fire)
        begin
            if (mode_reg != M_ERROR)
            begin
                unique case (mode_reg)
                    M_HDR_WS:
                    begin
                        if (!is_space(ch))
                        begin
                            if (ch == hdr_char(3'd0))
                            begin
                                hidx_next = 3'd1;
                                mode_next = M_HDR;
                            end
                            else
                            begin
                                b = push(b, K_ERR, E_HEADER, 16'(p), 16'(p1));
                                mode_next = M_ERROR;
                                pend_next = P_NONE;
                            end
                        end
                    end
                    M_HDR:
                    begin
                        if ((hidx_reg < HDR_LEN) && (ch == hdr_char(hidx_reg)))
                        begin
                            hidx_next = hidx_reg + 3'd1;
                            if (hidx_next == HDR_LEN)
                            begin
                                mode_next = M_IDLE;
                            end
                        end
                        else
                        begin
                            b = push(b, K_ERR, E_HEADER, 16'(p), 16'(p1));
                            mode_next = M_ERROR;
                            pend_next = P_NONE;
                        end
                    end
                    M_IDLE:
                    begin
                        if (pend_reg == P_SLASH)
                        begin
                            pend_next = P_NONE;
                            if (ch == "*")
                            begin
                                mode_next = M_COMMENT;
                                star_next = 1'b0;
                            end
                            else
                            begin
                                b = push(b, K_DIV, E_NONE, 16'(ts_reg), 16'(ts_reg + 1'b1));
                                do_idle = 1'b1;
                            end
                        end
                        else if (pend_reg == P_EQ)
                        begin
                            pend_next = P_NONE;
                            if (ch == " ")
                            begin
                                b = push(b, K_ASSIGN, E_NONE, 16'(ts_reg), 16'(p1));
                            end
                            else
                            begin
                                b = push(b, K_ERR, E_CHAR, 16'(ts_reg), 16'(ts_reg + 1'b1));
                                mode_next = M_ERROR;
                                pend_next = P_NONE;
                            end
                        end
                        else
                        begin
                            do_idle = 1'b1;
                        end
                    end
                    M_IDENT:
                    begin
                        if (!is_alpha(ch))
                        begin
                            b = push(b, K_IDENT, E_NONE, 16'(ts_reg), 16'(p));
                            do_idle = 1'b1;
                        end
                    end
                    M_INT:
                    begin
                        if (is_digit(ch))
                        begin
                            acc_next = {acc_reg[60:0], 3'b000} + {acc_reg[62:0], 1'b0}
                                       + 64'(digit);
                        end
                        else if (ch == ".")
                        begin
                            mode_next = M_DEC;
                            frac_next = '0;
                            fcnt_next = '0;
                        end
                        else
                        begin
                            b = push(b, K_INT, E_NONE, 16'(ts_reg), 16'(p));
                            b.int_value = acc_reg;
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    M_DEC:
                    begin
                        if (is_digit(ch))
                        begin
                            // drop digits past the kept precision
                            if (fcnt_reg < CNT_W'(MAX_FRAC_DIGITS))
                            begin
                                frac_next = {frac_reg[26:0], 3'b000} + {frac_reg[28:0], 1'b0}
                                            + 30'(digit);
                                fcnt_next = fcnt_reg + 1'b1;
                            end
                        end
                        else
                        begin
                            lit_next = lit_reg + 16'd1;
                            b = push(b, K_DEC, E_NONE, 16'(ts_reg), 16'(p));
                            b.int_value   = acc_reg;
                            b.frac_value  = frac_reg;
                            b.frac_digits = 4'(fcnt_reg);
                            b.lit_num     = lit_next;
                            mode_next = M_IDLE;
                            do_idle = 1'b1;
                        end
                    end
                    M_STR:
                    begin
                        if (ch == (quote_reg ? 8'h27 : 8'h22))
                        begin
                            lit_next = lit_reg + 16'd1;
                            b = push(b, K_STR, E_NONE, 16'(ts_reg), 16'(p));
                            b.lit_num = lit_next;
                            mode_next = M_IDLE;
                        end
                    end
                    M_COMMENT:
                    begin
                        if (star_reg && (ch == "/"))
                        begin
                            mode_next = M_IDLE;
                            star_next = 1'b0;
                        end
                        else
                        begin
                            star_next = (ch == "*");
                        end
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase

                // byte seen with no token open
                if (do_idle)
                begin
                    mode_next = M_IDLE;
                    if (!is_space(ch))
                    begin
                        unique case (ch)
                            "+": b = push(b, K_ADD, E_NONE, 16'(p), 16'(p1));
                            "-": b = push(b, K_SUB, E_NONE, 16'(p), 16'(p1));
                            "*": b = push(b, K_MUL, E_NONE, 16'(p), 16'(p1));
                            "(": b = push(b, K_LPAREN, E_NONE, 16'(p), 16'(p1));
                            ")": b = push(b, K_RPAREN, E_NONE, 16'(p), 16'(p1));
                            "/":
                            begin
                                pend_next = P_SLASH;
                                ts_next   = p;
                            end
                            "=":
                            begin
                                pend_next = P_EQ;
                                ts_next   = p;
                            end
                            8'h22, 8'h27:
                            begin
                                mode_next  = M_STR;
                                quote_next = (ch == 8'h27);
                                ts_next    = p1;
                            end
                            default:
                            begin
                                if (is_alpha(ch))
                                begin
                                    mode_next = M_IDENT;
                                    ts_next   = p;
                                end
                                else if (is_digit(ch))
                                begin
                                    mode_next = M_INT;
                                    ts_next   = p;
                                    acc_next  = 64'(digit);
                                    frac_next = '0;
                                    fcnt_next = '0;
                                end
                                else
                                begin
                                    b = push(b, K_ERR, E_CHAR, 16'(p), 16'(p1));
                                    mode_next = M_ERROR;
                                    pend_next = P_NONE;
                                end
                            end
                        endcase
                    end
                end
            end

            pos_next = p1;

            if (end_of_text)
            begin
                // flush the open token, then close the text
                if (mode_next != M_ERROR)
                begin
                    unique case (mode_next)
                        M_HDR_WS, M_HDR:
                        begin
                            b = push(b, K_ERR, E_HEADER, 16'(p1), 16'(p1));
                            mode_next = M_ERROR;
                        end
                        M_IDLE:
                        begin
                            if (pend_next == P_SLASH)
                            begin
                                b = push(b, K_DIV, E_NONE, 16'(ts_next),
                                         16'(ts_next + 1'b1));
                            end
                            else if (pend_next == P_EQ)
                            begin
                                b = push(b, K_ERR, E_CHAR, 16'(ts_next),
                                         16'(ts_next + 1'b1));
                                mode_next = M_ERROR;
                            end
                        end
                        M_IDENT:
                        begin
                            b = push(b, K_IDENT, E_NONE, 16'(ts_next), 16'(p1));
                            mode_next = M_IDLE;
                        end
                        M_INT:
                        begin
                            b = push(b, K_INT, E_NONE, 16'(ts_next), 16'(p1));
                            b.int_value = acc_next;
                            mode_next = M_IDLE;
                        end
                        M_DEC:
                        begin
                            lit_next = lit_next + 16'd1;
                            b = push(b, K_DEC, E_NONE, 16'(ts_next), 16'(p1));
                            b.int_value   = acc_next;
                            b.frac_value  = frac_next;
                            b.frac_digits = 4'(fcnt_next);
                            b.lit_num     = lit_next;
                            mode_next = M_IDLE;
                        end
                        M_STR:
                        begin
                            b = push(b, K_ERR, E_STRING, 16'(ts_next - 1'b1), 16'(p1));
                            mode_next = M_ERROR;
                        end
                        M_COMMENT:
                        begin
                            b = push(b, K_ERR, E_COMMENT, 16'(ts_next), 16'(p1));
                            mode_next = M_ERROR;
                        end
                        default:
                        begin
                            mode_next = M_ERROR;
                        end
                    endcase
                    if (mode_next != M_ERROR)
                    begin
                        b = push(b, K_EOF, E_NONE, 16'(p1), 16'(p1));
                    end
                end

                mode_next  = M_HDR_WS;
                hidx_next  = '0;
                pos_next   = '0;
                ts_next    = '0;
                acc_next   = '0;
                frac_next  = '0;
                fcnt_next  = '0;
                quote_next = 1'b0;
                pend_next  = P_NONE;
                star_next  = 1'b0;
                lit_next   = LIT_RESET;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_HDR_WS;
            hidx_reg  <= '0;
            pos_reg   <= '0;
            ts_reg    <= '0;
            acc_reg   <= '0;
            frac_reg  <= '0;
            fcnt_reg  <= '0;
            quote_reg <= 1'b0;
            pend_reg  <= P_NONE;
            star_reg  <= 1'b0;
            lit_reg   <= LIT_RESET;
        end
        else
        begin
            mode_reg  <= mode_next;
            hidx_reg  <= hidx_next;
            pos_reg   <= pos_next;
            ts_reg    <= ts_next;
            acc_reg   <= acc_next;
            frac_reg  <= frac_next;
            fcnt_reg  <= fcnt_next;
            quote_reg <= quote_next;
            pend_reg  <= pend_next;
            star_reg  <= star_next;
            lit_reg   <= lit_next;
        end
    end

    assign bundle = b;

endmodule

>>> design/elex_queue.sv
module elex_queue
    import elex_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr_en,
    input  bundle_t wr_data,
    output logic    full,
    input  logic    rd_en,
    output bundle_t head,
    output logic    empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bundle_t          store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] ptr);
        return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
    endfunction

    always_comb
    begin
        wr_ptr_next = wr_en ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = rd_en ? bump(rd_ptr_reg) : rd_ptr_reg;
        unique case ({wr_en, rd_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign head  = store_reg[rd_ptr_reg];
    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

endmodule

>>> design/elex_back.sv
module elex_back
    import elex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  bundle_t     head,
    input  logic        empty,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [2:0]  error_code,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [63:0] int_value,
    output logic [29:0] frac_value,
    output logic [3:0]  frac_digits,
    output logic [15:0] literal_number,
    output logic        last_result
);

    logic        valid_reg, valid_next;
    logic [1:0]  sel_reg, sel_next;
    kind_t       kind_reg, kind_next;
    err_t        err_reg, err_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] end_reg, end_next;
    logic [63:0] int_reg, int_next;
    logic [29:0] frac_reg, frac_next;
    logic [3:0]  fdig_reg, fdig_next;
    logic [15:0] lit_reg, lit_next;
    logic        last_reg, last_next;

    logic load;
    logic at_last;
    tok_t cur;

    assign load    = !valid_reg || out_ready;
    assign cur     = head.slot[sel_reg];
    assign at_last = (sel_reg == (head.count - 2'd1));
    assign pop     = load && !empty && at_last;

    always_comb
    begin
        valid_next = valid_reg;
        sel_next   = sel_reg;
        kind_next  = kind_reg;
        err_next   = err_reg;
        start_next = start_reg;
        end_next   = end_reg;
        int_next   = int_reg;
        frac_next  = frac_reg;
        fdig_next  = fdig_reg;
        lit_next   = lit_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                kind_next  = cur.kind;
                err_next   = cur.err;
                start_next = cur.start_pos;
                end_next   = cur.end_pos;
                // shared number fields belong only to the token that made them
                int_next   = ((cur.kind == K_INT) || (cur.kind == K_DEC)) ? head.int_value : '0;
                frac_next  = (cur.kind == K_DEC) ? head.frac_value : '0;
                fdig_next  = (cur.kind == K_DEC) ? head.frac_digits : '0;
                lit_next   = ((cur.kind == K_DEC) || (cur.kind == K_STR)) ? head.lit_num : '0;
                last_next  = at_last;
                sel_next   = at_last ? 2'd0 : sel_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sel_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            sel_reg   <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        err_reg   <= err_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        int_reg   <= int_next;
        frac_reg  <= frac_next;
        fdig_reg  <= fdig_next;
        lit_reg   <= lit_next;
        last_reg  <= last_next;
    end

    assign out_valid      = valid_reg;
    assign kind           = kind_reg;
    assign error_code     = err_reg;
    assign start_pos      = start_reg;
    assign end_pos        = end_reg;
    assign int_value      = int_reg;
    assign frac_value     = frac_reg;
    assign frac_digits    = fdig_reg;
    assign literal_number = lit_reg;
    assign last_result    = last_reg;

endmodule

>>> design/expression_lexer.sv
// Streaming lexer: source text in one byte per beat, tokens out one per beat.
//
// Input channel (in_valid/in_ready): ch is one byte of text, end_of_text marks
// the last byte of a text. The last byte also flushes the open token, emits
// EOF unless the text ends in error, then restores the post-reset state.
// Output channel (out_valid/out_ready): one token per beat with kind, error
// code, byte positions, number fields and literal number; last_result marks
// the final token caused by one input byte.
//
// Throughput: one byte per cycle. The front classifies a byte in the cycle it
// is taken and writes all tokens it causes (up to three) as one entry into a
// QUEUE_DEPTH-entry queue; the back drains one token per cycle as out_ready
// allows, so the tokens of one byte leave one after another. in_ready drops
// only while the queue is full.
// Path: a token is written into the queue, then into the output register.
// Reset: queue and output register empty, lexer waits for the header.
// Output stall: tokens pile up in the queue; once it fills, in_ready goes low
// and bytes wait upstream. No token is dropped.
module expression_lexer
    import elex_pkg::*;
#(
    parameter int POS_BITS        = POS_BITS_DEF,
    parameter int MAX_FRAC_DIGITS = MAX_FRAC_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ch,
    input  logic        end_of_text,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [2:0]  error_code,
    output logic [15:0] start_pos,
    output logic [15:0] end_pos,
    output logic [63:0] int_value,
    output logic [29:0] frac_value,
    output logic [3:0]  frac_digits,
    output logic [15:0] literal_number,
    output logic        last_result
);

    logic    in_fire;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    q_wr;
    bundle_t fe_bundle;
    bundle_t q_head;

    // take a byte whenever the queue has room for its tokens
    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;
    // bytes that make no token leave nothing in the queue
    assign q_wr     = in_fire && (fe_bundle.count != 2'd0);

    elex_front #(
        .POS_BITS        (POS_BITS),
        .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .ch          (ch),
        .end_of_text (end_of_text),
        .bundle      (fe_bundle)
    );

    elex_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (fe_bundle),
        .full    (q_full),
        .rd_en   (q_pop),
        .head    (q_head),
        .empty   (q_empty)
    );

    elex_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head           (q_head),
        .empty          (q_empty),
        .pop            (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .error_code     (error_code),
        .start_pos      (start_pos),
        .end_pos        (end_pos),
        .int_value      (int_value),
        .frac_value     (frac_value),
        .frac_digits    (frac_digits),
        .literal_number (literal_number),
        .last_result    (last_result)
    );

`ifndef SYNTHESIS
    // EOF and errors always close the token group of their byte
    a_final_kinds_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && ((kind == K_EOF) || (kind == K_ERR)) |-> last_result)
        else $error("EOF or error token not marked as last result");

    // shared number fields must not leak onto other tokens of a group
    a_int_only_numbers: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != K_INT) && (kind != K_DEC) |-> (int_value == '0))
        else $error("int_value set on a non-number token");

    a_lit_only_literals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != K_DEC) && (kind != K_STR) |-> (literal_number == '0))
        else $error("literal_number set on a non-literal token");
`endif

endmodule
